// File: hw/rtl/mlpq_pkg.sv
// ----------------------------------------------------------------------------
// mlpq_pkg
// Opcodes, status codes and fixed field widths of the priority request queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpq_pkg;

  localparam int ID_W     = 48;
  localparam int TAG_W    = 16;
  localparam int OP_W     = 3;
  localparam int LVLF_W   = 3;
  localparam int PEND_W   = 7;
  localparam int CTR_W    = 32;

  localparam logic [OP_W-1:0] OP_ENQUEUE  = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE  = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND     = 3'd2;
  localparam logic [OP_W-1:0] OP_COMPLETE = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

endpackage

`default_nettype wire

// File: hw/rtl/multilevel_priority_request_queue.sv
// ----------------------------------------------------------------------------
// multilevel_priority_request_queue
// Multi-level FIFO request queue over one shared entry store.
// ----------------------------------------------------------------------------
// Each item on s_* is one command; each produces exactly one result item on
// m_*. Entries (id, tag) live in one synchronous memory and the chain links
// of the per-level FIFOs and the free stack in a second one, both with one
// write and one registered read port. Each item runs S_EXEC and then S_OUT;
// enqueue adds S_FREEPOP when a recycled entry is popped off the free stack,
// dequeue adds S_DEQ2 unless nothing is held, and find walks S_FIND/S_FCHK
// per entry (levels searched from 0 up in FIFO order, plus one S_FIND per
// level passed), so find is bound by the link-memory read latency of the
// walk. A new item is taken while the previous result still waits in the
// output register. No clearing pass: never-used entries are handed out from
// a fill pointer, and released entries are pushed on a linked free stack;
// flush just resets both.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_priority_request_queue
  import mlpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int LEVELS   = 5
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // s_tdata: op[2:0], level[5:3], req_id[53:6], request_tag[69:54], failed[70]
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [71:0]  s_tdata,
  // m_tdata: status[1:0], out_id[49:2], out_tag[65:50], out_level[68:66],
  //          pending_count[75:69], total_count[107:76], completed_count[139:108],
  //          failed_count[171:140]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [175:0]      m_tdata,
  // pending_limit write
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [6:0]   cfg_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DAT_W = ID_W + TAG_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_FREEPOP, S_DEQ2, S_FIND, S_FCHK, S_OUT
  } state_t;

  state_t state;

  // captured command
  logic [OP_W-1:0]   op;
  logic [LVLF_W-1:0] lvl;
  logic [ID_W-1:0]   rid;
  logic [TAG_W-1:0]  tag;
  logic              fail;

  // queue bookkeeping
  logic [IDX_W-1:0] heads  [LEVELS];
  logic [IDX_W-1:0] tails  [LEVELS];
  logic [CNT_W-1:0] counts [LEVELS];
  logic [IDX_W-1:0] free_head;
  logic [CNT_W-1:0] free_cnt;   // entries on the linked free stack
  logic [CNT_W-1:0] fresh;      // entries below this were handed out at least once
  logic [CNT_W-1:0] pending;
  logic [CTR_W-1:0] total, completed, failed_total;
  logic [ID_W-1:0]  id_counter;
  logic [6:0]       pending_limit;

  // walk / dequeue context
  logic [IDX_W-1:0] ptr;
  logic [LVL_W-1:0] wlvl;
  logic [CNT_W-1:0] remaining;

  // result register
  logic [1:0]        r_status;
  logic [ID_W-1:0]   r_id;
  logic [TAG_W-1:0]  r_tag;
  logic [LVLF_W-1:0] r_level;

  // memories
  logic [DAT_W-1:0] data_mem [CAPACITY];
  logic [IDX_W-1:0] link_mem [CAPACITY];
  logic [DAT_W-1:0] data_rdata;
  logic [IDX_W-1:0] link_rdata;
  logic             data_we, link_we, rd_en;
  logic [IDX_W-1:0] data_waddr, link_waddr, link_wdata, rd_addr;
  logic [DAT_W-1:0] data_wdata;

  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_waddr] <= data_wdata;
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (rd_en) begin
      data_rdata <= data_mem[rd_addr];
      link_rdata <= link_mem[rd_addr];
    end
  end

  // decode
  logic              lvl_ok;
  logic [LVL_W-1:0]  lidx;
  logic              full;
  logic [IDX_W-1:0]  alloc;
  logic [ID_W-1:0]   new_id;
  logic [ID_W-1:0]   id_next;
  logic              deq_hit;
  logic [LVL_W-1:0]  deq_lvl;

  always_comb begin
    lvl_ok  = 32'(lvl) < LEVELS;
    lidx    = LVL_W'(lvl);
    full    = (pending_limit != 7'd0 && 32'(pending) >= 32'(pending_limit)) ||
              32'(pending) >= CAPACITY;
    alloc   = (free_cnt != '0) ? free_head : IDX_W'(fresh);
    id_next = id_counter + ID_W'(1);
    new_id  = (rid == '0) ? id_next : rid;
    deq_hit = 1'b0;
    deq_lvl = '0;
    if (lvl_ok) begin
      deq_hit = counts[lidx] != '0;
      deq_lvl = lidx;
    end else begin
      for (int l = LEVELS - 1; l >= 0; l--) begin
        if (counts[l] != '0) begin
          deq_hit = 1'b1;
          deq_lvl = LVL_W'(l);
        end
      end
    end
  end

  // memory port control
  always_comb begin
    data_we    = 1'b0;
    link_we    = 1'b0;
    rd_en      = 1'b0;
    data_waddr = alloc;
    data_wdata = {tag, new_id};
    link_waddr = tails[lidx];
    link_wdata = alloc;
    rd_addr    = free_head;
    case (state)
      S_EXEC: begin
        if (op == OP_ENQUEUE && lvl_ok && !full) begin
          data_we = 1'b1;
          link_we = counts[lidx] != '0;
          rd_en   = free_cnt != '0;
        end else if (op == OP_DEQUEUE && deq_hit) begin
          rd_en   = 1'b1;
          rd_addr = heads[deq_lvl];
        end
      end
      S_DEQ2: begin
        link_we    = 1'b1;
        link_waddr = ptr;
        link_wdata = free_head;
      end
      S_FIND: begin
        rd_en   = remaining != '0;
        rd_addr = ptr;
      end
      default: ;
    endcase
  end

  assign s_tready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      free_head     <= '0;
      free_cnt      <= '0;
      fresh         <= '0;
      pending       <= '0;
      total         <= '0;
      completed     <= '0;
      failed_total  <= '0;
      id_counter    <= ID_W'(1);
      pending_limit <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        heads[l]  <= '0;
        tails[l]  <= '0;
        counts[l] <= '0;
      end
    end else begin
      if (cfg_valid) pending_limit <= cfg_data;
      // S_OUT reloads the output register itself
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tdata[2:0];
            lvl   <= s_tdata[5:3];
            rid   <= s_tdata[53:6];
            tag   <= s_tdata[69:54];
            fail  <= s_tdata[70];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op)
            OP_ENQUEUE: begin
              if (!lvl_ok || full) begin
                r_status <= lvl_ok ? ST_FULL : ST_INVALID;
                r_id     <= '0;
                r_tag    <= '0;
                r_level  <= '0;
                state    <= S_OUT;
              end else begin
                if (rid == '0) id_counter <= id_next;
                if (counts[lidx] == '0) heads[lidx] <= alloc;
                tails[lidx]  <= alloc;
                counts[lidx] <= counts[lidx] + CNT_W'(1);
                pending      <= pending + CNT_W'(1);
                total        <= total + CTR_W'(1);
                r_status     <= ST_OK;
                r_id         <= new_id;
                r_tag        <= tag;
                r_level      <= lvl;
                if (free_cnt != '0) begin
                  free_cnt <= free_cnt - CNT_W'(1);
                  state    <= S_FREEPOP;
                end else begin
                  fresh <= fresh + CNT_W'(1);
                  state <= S_OUT;
                end
              end
            end
            OP_DEQUEUE: begin
              if (!deq_hit) begin
                r_status <= ST_EMPTY;
                r_id     <= '0;
                r_tag    <= '0;
                r_level  <= '0;
                state    <= S_OUT;
              end else begin
                ptr   <= heads[deq_lvl];
                wlvl  <= deq_lvl;
                state <= S_DEQ2;
              end
            end
            OP_FIND: begin
              if (rid == '0) begin
                r_status <= ST_INVALID;
                r_id     <= '0;
                r_tag    <= '0;
                r_level  <= '0;
                state    <= S_OUT;
              end else begin
                wlvl      <= '0;
                ptr       <= heads[0];
                remaining <= counts[0];
                state     <= S_FIND;
              end
            end
            OP_COMPLETE: begin
              if (fail) failed_total <= failed_total + CTR_W'(1);
              else      completed    <= completed + CTR_W'(1);
              r_status <= ST_OK;
              r_id     <= '0;
              r_tag    <= '0;
              r_level  <= '0;
              state    <= S_OUT;
            end
            OP_FLUSH: begin
              free_cnt <= '0;
              fresh    <= '0;
              pending  <= '0;
              for (int l = 0; l < LEVELS; l++) counts[l] <= '0;
              r_status <= ST_OK;
              r_id     <= '0;
              r_tag    <= '0;
              r_level  <= '0;
              state    <= S_OUT;
            end
            default: begin
              r_status <= ST_INVALID;
              r_id     <= '0;
              r_tag    <= '0;
              r_level  <= '0;
              state    <= S_OUT;
            end
          endcase
        end
        S_FREEPOP: begin
          free_head <= link_rdata;
          state     <= S_OUT;
        end
        S_DEQ2: begin
          heads[wlvl]  <= link_rdata;
          counts[wlvl] <= counts[wlvl] - CNT_W'(1);
          pending      <= pending - CNT_W'(1);
          free_head    <= ptr;
          free_cnt     <= free_cnt + CNT_W'(1);
          r_status     <= ST_OK;
          r_id         <= data_rdata[ID_W-1:0];
          r_tag        <= data_rdata[DAT_W-1:ID_W];
          r_level      <= LVLF_W'(wlvl);
          state        <= S_OUT;
        end
        S_FIND: begin
          if (remaining != '0) begin
            state <= S_FCHK;
          end else if (32'(wlvl) == LEVELS - 1) begin
            r_status <= ST_EMPTY;
            r_id     <= '0;
            r_tag    <= '0;
            r_level  <= '0;
            state    <= S_OUT;
          end else begin
            wlvl      <= wlvl + LVL_W'(1);
            ptr       <= heads[wlvl + LVL_W'(1)];
            remaining <= counts[wlvl + LVL_W'(1)];
          end
        end
        S_FCHK: begin
          if (data_rdata[ID_W-1:0] == rid) begin
            r_status <= ST_OK;
            r_id     <= rid;
            r_tag    <= data_rdata[DAT_W-1:ID_W];
            r_level  <= LVLF_W'(wlvl);
            state    <= S_OUT;
          end else begin
            ptr       <= link_rdata;
            remaining <= remaining - CNT_W'(1);
            state     <= S_FIND;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, failed_total, completed, total, PEND_W'(pending),
                         r_level, r_tag, r_id, r_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // every handed-out entry is either held in a level or on the free stack
  a_entry_conservation: assert property (@(posedge clk) disable iff (rst)
    32'(fresh) == 32'(free_cnt) + 32'(pending))
    else $error("entry bookkeeping out of balance");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pending) <= CAPACITY)
    else $error("pending count above capacity");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_EXEC)
    else $error("accepted item not dispatched");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multilevel priority request queue.
// ----------------------------------------------------------------------------
// Commands go in through a driver fed from a queue; a scoreboard model of the
// level FIFOs predicts each result, and a monitor compares every result item
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mlpq_pkg::*;

  localparam int CAP = 64;
  localparam int NLVL = 5;

  typedef struct packed {
    logic             failed;
    logic [TAG_W-1:0] tag;
    logic [ID_W-1:0]  id;
    logic [2:0]       lvl;
    logic [OP_W-1:0]  op;
  } cmd_t;

  typedef struct packed {
    logic [CTR_W-1:0]  fails;
    logic [CTR_W-1:0]  dones;
    logic [CTR_W-1:0]  accepted;
    logic [PEND_W-1:0] pending;
    logic [2:0]        lvl;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   id;
    logic [1:0]        status;
  } res_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
  logic [71:0] s_tdata = '0;
  logic [175:0] m_tdata;
  logic cfg_valid = 0, cfg_ready;
  logic [6:0] cfg_data = '0;

  multilevel_priority_request_queue dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always #4 clk = ~clk;

  // queue model: each level a FIFO of {id, tag}
  logic [63:0] lvl_q[NLVL][$];
  logic [ID_W-1:0] next_id;
  logic [6:0] limit_reg;
  logic [31:0] n_acc, n_ok, n_err;
  res_t expected_q[$];
  cmd_t pending_cmds[$];
  int errors = 0, n_checked = 0, n_sent = 0, n_driven = 0;
  logic [ID_W-1:0] used_ids[$];

  function automatic int held();
    int n = 0;
    for (int l = 0; l < NLVL; l++) n += lvl_q[l].size();
    return n;
  endfunction

  function automatic res_t predict_result(cmd_t c);
    res_t r;
    logic [63:0] e;
    int lo, hi;
    logic [ID_W-1:0] rid;
    r = '0;
    rid = c.id;
    case (c.op)
      OP_ENQUEUE: begin
        if (c.lvl >= NLVL) r.status = ST_INVALID;
        else if ((limit_reg != 0 && held() >= limit_reg) || held() >= CAP)
          r.status = ST_FULL;
        else begin
          if (rid == 0) begin
            next_id = next_id + 1;
            rid = next_id;
          end
          lvl_q[c.lvl].push_back({rid, c.tag});
          n_acc++;
          r.id = rid; r.tag = c.tag; r.lvl = c.lvl;
        end
      end
      OP_DEQUEUE: begin
        lo = c.lvl < NLVL ? c.lvl : 0;
        hi = c.lvl < NLVL ? c.lvl : NLVL - 1;
        r.status = ST_EMPTY;
        for (int l = lo; l <= hi; l++) begin
          if (lvl_q[l].size() != 0) begin
            e = lvl_q[l].pop_front();
            r.id = e[63:16]; r.tag = e[15:0]; r.lvl = 3'(l); r.status = ST_OK;
            break;
          end
        end
      end
      OP_FIND: begin
        if (rid == 0) r.status = ST_INVALID;
        else begin
          r.status = ST_EMPTY;
          for (int l = 0; l < NLVL && r.status != ST_OK; l++)
            foreach (lvl_q[l][k])
              if (lvl_q[l][k][63:16] == rid) begin
                r.id = rid; r.tag = lvl_q[l][k][15:0]; r.lvl = 3'(l);
                r.status = ST_OK;
                break;
              end
        end
      end
      OP_COMPLETE: if (c.failed) n_err++; else n_ok++;
      OP_FLUSH: for (int l = 0; l < NLVL; l++) lvl_q[l].delete();
      default: r.status = ST_INVALID;
    endcase
    r.pending = PEND_W'(held());
    r.accepted = n_acc; r.dones = n_ok; r.fails = n_err;
    return r;
  endfunction

  // acceptance is sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_q.push_back(predict_result(s_tdata[70:0]));
      n_sent++;
    end
  end

  // driver: bursts with random gaps
  int gap = 0, burst = 0;
  logic hold = 0;
  always @(negedge clk) begin
    if (!rst) begin
      // current item gone (or none shown): pick what comes next
      if (!s_tvalid || n_sent == n_driven) begin
        if (hold || pending_cmds.size() == 0) s_tvalid <= 0;
        else if (gap > 0) begin
          gap--; s_tvalid <= 0;
        end else begin
          s_tvalid <= 1;
          s_tdata <= {1'b0, pending_cmds.pop_front()};
          n_driven++;
          if (burst > 0) burst--;
          else begin
            burst = $urandom_range(0, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
      end
      // receiver stall pattern: runs of ready and not ready
      m_tready <= ($urandom_range(0, 99) < (n_sent % 300 < 100 ? 100 : 65));
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[171:0];
      n_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.status !== exp_r.status || got.id !== exp_r.id ||
            got.tag !== exp_r.tag || got.lvl !== exp_r.lvl ||
            got.pending !== exp_r.pending || got.accepted !== exp_r.accepted ||
            got.dones !== exp_r.dones || got.fails !== exp_r.fails) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch #%0d: exp st=%0d id=%h tag=%h lvl=%0d pend=%0d acc=%0d ok=%0d err=%0d",
              n_checked, exp_r.status, exp_r.id, exp_r.tag, exp_r.lvl, exp_r.pending,
              exp_r.accepted, exp_r.dones, exp_r.fails);
            $display("  got st=%0d id=%h tag=%h lvl=%0d pend=%0d acc=%0d ok=%0d err=%0d",
              got.status, got.id, got.tag, got.lvl, got.pending, got.accepted,
              got.dones, got.fails);
          end
        end
      end
    end
  end

  function automatic cmd_t mk(logic [2:0] op, logic [2:0] lvl, logic [ID_W-1:0] id,
                              logic [TAG_W-1:0] tag, logic failed);
    cmd_t c;
    c.op = op; c.lvl = lvl; c.id = id; c.tag = tag; c.failed = failed;
    return c;
  endfunction

  // random id: half auto, sometimes full-width random, sometimes reused
  function automatic logic [ID_W-1:0] rand_id();
    int k = $urandom_range(0, 9);
    if (k < 5) return '0;
    if (k < 7 && used_ids.size() != 0)
      return used_ids[$urandom_range(0, used_ids.size() - 1)];
    return ID_W'({$urandom, $urandom});
  endfunction

  function automatic cmd_t rand_cmd(int fill_bias);
    int k = $urandom_range(0, 99);
    logic [ID_W-1:0] id;
    logic [2:0] lv;
    lv = 3'($urandom_range(0, 7));
    if (k < fill_bias) begin
      id = rand_id();
      if (id != 0) used_ids.push_back(id);
      lv = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
           3'($urandom_range(0, 4));
      return mk(OP_ENQUEUE, lv, id, TAG_W'($urandom), 1'($urandom));
    end
    if (k < 80)
      return mk(OP_DEQUEUE, lv, rand_id(), TAG_W'($urandom), 1'($urandom));
    if (k < 90) begin
      id = (used_ids.size() != 0 && $urandom_range(0, 3) != 0) ?
           used_ids[$urandom_range(0, used_ids.size() - 1)] : rand_id();
      return mk(OP_FIND, lv, id, TAG_W'($urandom), 1'($urandom));
    end
    if (k < 96)
      return mk(OP_COMPLETE, lv, rand_id(), TAG_W'($urandom), 1'($urandom));
    if (k < 98)
      return mk(OP_FLUSH, lv, rand_id(), TAG_W'($urandom), 1'($urandom));
    return mk(3'($urandom_range(5, 7)), lv, rand_id(), TAG_W'($urandom), 1'($urandom));
  endfunction

  task automatic drain_and_idle();
    wait (pending_cmds.size() == 0 && !s_tvalid);
    hold = 1;
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_limit(logic [6:0] v);
    @(negedge clk);
    cfg_valid <= 1; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    limit_reg = v;
  endtask

  initial begin
    logic [6:0] limits[5] = '{7'd0, 7'd64, 7'd1, 7'd7, 7'd127};
    next_id = 1; limit_reg = 0; n_acc = 0; n_ok = 0; n_err = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 0;
    // directed: extremes, each op, each corner
    pending_cmds.push_back(mk(OP_DEQUEUE, 3'd7, '0, '0, 1'b0));     // empty, any level
    pending_cmds.push_back(mk(OP_DEQUEUE, 3'd2, '0, '0, 1'b0));     // empty, one level
    pending_cmds.push_back(mk(OP_FIND, 3'd0, '0, '0, 1'b0));        // zero id
    pending_cmds.push_back(mk(OP_FIND, 3'd0, 48'h5, '0, 1'b0));     // not held
    pending_cmds.push_back(mk(OP_ENQUEUE, 3'd5, '0, '0, 1'b0));     // bad level
    pending_cmds.push_back(mk(OP_ENQUEUE, 3'd7, '1, '1, 1'b1));
    pending_cmds.push_back(mk(OP_ENQUEUE, 3'd4, '0, 16'hFFFF, 1'b1));
    pending_cmds.push_back(mk(OP_ENQUEUE, 3'd0, '1, 16'h0000, 1'b0));
    pending_cmds.push_back(mk(OP_ENQUEUE, 3'd2, 48'hAAAA_5555_AAAA, 16'h5A5A, 1'b0));
    pending_cmds.push_back(mk(OP_ENQUEUE, 3'd2, '0, 16'h1234, 1'b1));
    pending_cmds.push_back(mk(OP_FIND, 3'd6, '1, '0, 1'b0));
    pending_cmds.push_back(mk(OP_FIND, 3'd0, 48'hAAAA_5555_AAAA, '0, 1'b0));
    pending_cmds.push_back(mk(OP_DEQUEUE, 3'd2, '0, '0, 1'b0));
    pending_cmds.push_back(mk(OP_DEQUEUE, 3'd5, '0, '0, 1'b0));
    pending_cmds.push_back(mk(OP_DEQUEUE, 3'd1, '0, '0, 1'b0));
    pending_cmds.push_back(mk(OP_COMPLETE, 3'd0, '1, '1, 1'b0));
    pending_cmds.push_back(mk(OP_COMPLETE, 3'd7, '0, '0, 1'b1));
    pending_cmds.push_back(mk(3'd5, 3'd0, '0, '0, 1'b0));
    pending_cmds.push_back(mk(3'd7, 3'd7, '1, '1, 1'b1));
    pending_cmds.push_back(mk(OP_FLUSH, 3'd0, '0, '0, 1'b0));
    pending_cmds.push_back(mk(OP_DEQUEUE, 3'd6, '0, '0, 1'b0));
    drain_and_idle();
    // random phases, each under its own pending limit; enqueue bias varies fill level
    foreach (limits[p]) begin
      write_limit(limits[p]);
      for (int i = 0; i < 180; i++)
        pending_cmds.push_back(rand_cmd((i / 45) % 2 ? 40 : 70));
      hold = 0;
      drain_and_idle();
    end
    hold = 0;
    $display("covered %0d items, limits 0/1/7/64/127, all ops incl. full and empty cases",
             n_sent);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: multilevel_priority_request_queue.f
hw/rtl/mlpq_pkg.sv
hw/rtl/multilevel_priority_request_queue.sv
bench/testbench.sv
